FILE: rtl/adchs_pkg.sv
// ----------------------------------------------------------------------------
// adchs_pkg
// Shared types and codes for the ADC conversion handshake tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package adchs_pkg;

    // Event commands
    localparam logic [2:0] CMD_START        = 3'd0;
    localparam logic [2:0] CMD_OBSERVE_BUSY = 3'd1;
    localparam logic [2:0] CMD_FALL_EDGE    = 3'd2;
    localparam logic [2:0] CMD_TAKE_READY   = 3'd3;
    localparam logic [2:0] CMD_FINISH_READ  = 3'd4;
    localparam logic [2:0] CMD_TAKE_TIMEOUT = 3'd5;
    localparam logic [2:0] CMD_RECOVER      = 3'd6;
    localparam logic [2:0] CMD_RESERVED     = 3'd7;   // no action

    // Conversion phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_HIGH = 3'd1;
    localparam logic [2:0] PH_WAIT_LOW  = 3'd2;
    localparam logic [2:0] PH_READY     = 3'd3;
    localparam logic [2:0] PH_READING   = 3'd4;
    localparam logic [2:0] PH_FAULT     = 3'd5;

    localparam logic [31:0] TIMEOUT_LIMIT_RESET = 32'd10;

    typedef struct packed {
        logic [2:0]  command;
        logic        busy_high;
        logic [31:0] now_ms;
    } adchs_in_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  phase;
        logic [31:0] spurious_count;
        logic        timeout_flag;
    } adchs_out_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] start_time;
        logic [31:0] edge_counter;
        logic        tmo_flag;
    } adchs_state_t;

endpackage

`default_nettype wire

FILE: rtl/adc_conversion_handshake_fsm_unit.sv
// ----------------------------------------------------------------------------
// adc_conversion_handshake_fsm_unit
// Tracks one ADC conversion through its busy-line handshake.
// ----------------------------------------------------------------------------
// Each event item (command, sampled busy level, millisecond time) yields
// exactly one result item: accepted strobe, phase after the event, spurious
// falling-edge count and pending timeout flag. An accepted event item passes
// through the input register, then the result register, which holds its
// result item valid until taken; one item per clock is sustained while
// m_ready stays high, since the whole phase update is a single
// subtract/compare plus selection between the two registers. The tracker
// state is written at the same edge that loads the result, so consecutive
// items see each other's effects with no bubbles. timeout_limit resets to
// 10 ms and is written through the cfg_* channel, which is always ready;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_conversion_handshake_fsm_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // event items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire adchs_pkg::adchs_in_t  s_data,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output adchs_pkg::adchs_out_t      m_data,
    // timeout_limit register write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [31:0]           cfg_data
);
    import adchs_pkg::*;

    logic         q_valid;
    adchs_in_t    q_data;
    logic         advance;

    adchs_state_t state_reg;
    adchs_state_t state_next;
    adchs_out_t   result_next;
    adchs_out_t   result_reg;
    logic         m_valid_reg;
    logic         m_valid_next;
    logic [31:0]  timeout_limit_reg;

    // An item moves out of the input register when the result slot is free
    // or is being drained this cycle.
    assign advance = q_valid && (!m_valid_reg || m_ready);

    adchs_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (advance),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    adchs_step u_step (
        .ev            (q_data),
        .cur           (state_reg),
        .timeout_limit (timeout_limit_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end else if (cfg_valid) begin
            timeout_limit_reg <= cfg_data;
        end
    end

    // Tracker state commits together with the result it produced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = result_reg;

endmodule

`default_nettype wire

FILE: rtl/adchs_in_reg.sv
// ----------------------------------------------------------------------------
// adchs_in_reg
// Input register stage; holds one event item until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module adchs_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire adchs_pkg::adchs_in_t s_data,
    input  wire logic              take,
    output logic                   q_valid,
    output adchs_pkg::adchs_in_t   q_data
);
    import adchs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    adchs_in_t data_reg;

    // Slot frees up when its item is taken the same cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/adchs_step.sv
// ----------------------------------------------------------------------------
// adchs_step
// Next-state and result logic for one event item.
// ----------------------------------------------------------------------------
`default_nettype none

module adchs_step (
    input  wire adchs_pkg::adchs_in_t    ev,
    input  wire adchs_pkg::adchs_state_t cur,
    input  wire logic [31:0]             timeout_limit,
    output adchs_pkg::adchs_state_t      nxt,
    output adchs_pkg::adchs_out_t        res
);
    import adchs_pkg::*;

    logic [31:0] elapsed;
    logic        timed_out;
    logic [2:0]  obs_phase;
    logic        accepted;

    assign elapsed   = ev.now_ms - cur.start_time;
    assign timed_out = (elapsed >= timeout_limit);

    // Phase after a busy observation, before the timeout check
    always_comb begin
        obs_phase = cur.phase;
        if (cur.phase == PH_WAIT_HIGH && ev.busy_high) begin
            obs_phase = PH_WAIT_LOW;
        end else if (cur.phase == PH_WAIT_LOW && !ev.busy_high) begin
            obs_phase = PH_READY;
        end
    end

    always_comb begin
        nxt      = cur;
        accepted = 1'b0;
        unique case (ev.command)
            CMD_START: begin
                if (cur.phase == PH_IDLE) begin
                    nxt.start_time      = ev.now_ms;
                    nxt.tmo_flag        = 1'b0;
                    nxt.phase           = ev.busy_high ? PH_WAIT_LOW : PH_WAIT_HIGH;
                    accepted            = 1'b1;
                end
            end
            CMD_OBSERVE_BUSY: begin
                nxt.phase = obs_phase;
                if ((obs_phase == PH_WAIT_HIGH || obs_phase == PH_WAIT_LOW) && timed_out) begin
                    nxt.phase           = PH_FAULT;
                    nxt.tmo_flag        = 1'b1;
                end
            end
            CMD_FALL_EDGE: begin
                if (cur.phase == PH_WAIT_LOW && !ev.busy_high) begin
                    nxt.phase = PH_READY;
                end else begin
                    nxt.edge_counter = cur.edge_counter + 32'd1;
                end
            end
            CMD_TAKE_READY: begin
                if (cur.phase == PH_READY) begin
                    nxt.phase = PH_READING;
                    accepted  = 1'b1;
                end
            end
            CMD_FINISH_READ: begin
                if (cur.phase == PH_READING) begin
                    nxt.phase = PH_IDLE;
                end
            end
            CMD_TAKE_TIMEOUT: begin
                accepted            = cur.tmo_flag;
                nxt.tmo_flag        = 1'b0;
            end
            CMD_RECOVER: begin
                nxt.phase           = PH_IDLE;
                nxt.tmo_flag        = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign res.accepted       = accepted;
    assign res.phase          = nxt.phase;
    assign res.spurious_count = nxt.edge_counter;
    assign res.timeout_flag   = nxt.tmo_flag;

endmodule

`default_nettype wire
